// ===== rtl/atw2d_pkg.sv =====
// Shared types and constants for the 2D affine world-transform core.
// No dependencies; imported by atw2d_sin and the top level.
package atw2d_pkg;

    // Quarter-wave sine polynomial coefficients, Q16
    localparam logic [16:0] SinA = 17'd102944;
    localparam logic [15:0] SinB = 16'd42047;
    localparam logic [12:0] SinC = 13'd4639;

    // One quarter turn in binary angle units
    localparam logic [15:0] QuarterTurn = 16'd16384;

    // Sine latency in register stages
    localparam int SinStages = 4;

    // Fields that ride alongside the sine pipeline
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [23:0] scale_x;
        logic signed [23:0] scale_y;
        logic signed [31:0] pa;
        logic signed [31:0] pb;
        logic signed [31:0] pc;
        logic signed [31:0] pd;
        logic signed [31:0] ptx;
        logic signed [31:0] pty;
    } t_side;

endpackage

// ===== rtl/atw2d_sin.sv =====
// Four-stage pipelined binary-angle sine, Q16 result in -65536..65536.
// Depends on atw2d_pkg for the polynomial coefficients.
module atw2d_sin import atw2d_pkg::*; (
    input  logic               i_clk,
    input  logic [15:0]        i_angle,
    output logic signed [18:0] o_sin
);

    logic [14:0] n_z;
    logic [14:0] r_z1, r_z2, r_z3;
    logic        r_neg1, r_neg2, r_neg3;
    logic [29:0] n_zz;
    logic [14:0] r_zsq1, r_zsq2;
    logic [27:0] n_c2;
    logic [15:0] n_t1, r_t1;
    logic [30:0] n_c3;
    logic [16:0] n_t2, r_t2;
    logic [31:0] n_c4;
    logic [17:0] n_mag;
    logic signed [18:0] r_sin;

    // Fold the angle into the first quadrant and form the polynomial terms
    always_comb begin
        if (i_angle[14]) begin
            n_z = 15'(QuarterTurn) - {1'b0, i_angle[13:0]};
        end else begin
            n_z = {1'b0, i_angle[13:0]};
        end
        n_zz  = n_z * n_z;
        n_c2  = r_zsq1 * SinC;
        n_t1  = SinB - 16'(n_c2 >> 14);
        n_c3  = r_zsq2 * r_t1;
        n_t2  = SinA - 17'(n_c3 >> 14);
        n_c4  = r_z3 * r_t2;
        n_mag = 18'(n_c4 >> 14);
    end

    always_ff @(posedge i_clk) begin
        r_z1   <= n_z;
        r_neg1 <= i_angle[15];
        r_zsq1 <= 15'(n_zz >> 14);
        r_z2   <= r_z1;
        r_neg2 <= r_neg1;
        r_zsq2 <= r_zsq1;
        r_t1   <= n_t1;
        r_z3   <= r_z2;
        r_neg3 <= r_neg2;
        r_t2   <= n_t2;
        r_sin  <= r_neg3 ? -$signed({1'b0, n_mag}) : $signed({1'b0, n_mag});
    end

    assign o_sin = r_sin;

endmodule

// ===== rtl/affine_trs_world_transform_2d_core.sv =====
// Top level: node TRS plus parent matrix in, world matrix out, Q16.16 saturated.
// Depends on atw2d_pkg and two atw2d_sin instances (sine and cosine).
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------
//  input   | start & !busy         | i_pos_x/y, i_angle, i_scale_x/y, i_parent_*
//  result  | o_valid, one cycle    | o_world_a/b/c/d/tx/ty, o_clipped
//
// A beat runs through the sine, local, product and output stages, with o_valid.
// One beat enters every cycle; the 12 parallel multipliers (up to 32x32) of the
// product stage and the four-multiply sine chain set the stage count.
// busy is always low: the receiver cannot stall, so the pipeline never holds.
// Reset clears only the valid bits; payload registers carry no reset.
module affine_trs_world_transform_2d_core import atw2d_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic [15:0]        i_angle,
    input  logic signed [23:0] i_scale_x,
    input  logic signed [23:0] i_scale_y,
    input  logic signed [31:0] i_parent_a,
    input  logic signed [31:0] i_parent_b,
    input  logic signed [31:0] i_parent_c,
    input  logic signed [31:0] i_parent_d,
    input  logic signed [31:0] i_parent_tx,
    input  logic signed [31:0] i_parent_ty,
    output logic               o_valid,
    output logic signed [31:0] o_world_a,
    output logic signed [31:0] o_world_b,
    output logic signed [31:0] o_world_c,
    output logic signed [31:0] o_world_d,
    output logic signed [31:0] o_world_tx,
    output logic signed [31:0] o_world_ty,
    output logic               o_clipped
);

    typedef struct packed {
        logic [31:0] val;
        logic        clip;
    } t_ent;

    // Round (p + q) half up to Q16.16, add the bias, saturate and flag
    function automatic t_ent combine(input logic signed [63:0] p,
                                     input logic signed [63:0] q,
                                     input logic signed [31:0] b);
        logic signed [66:0] sum;
        logic signed [50:0] r;
        t_ent e;
        sum = 67'(p) + 67'(q) + (67'(b) <<< 16) + 67'sd32768;
        r   = sum[66:16];
        if (r > 51'sd2147483647) begin
            e.val  = 32'h7FFF_FFFF;
            e.clip = 1'b1;
        end else if (r < -51'sd2147483648) begin
            e.val  = 32'h8000_0000;
            e.clip = 1'b1;
        end else begin
            e.val  = r[31:0];
            e.clip = 1'b0;
        end
        return e;
    endfunction

    logic               accept;
    logic [6:0]         r_vld;
    t_side              n_side;
    t_side              r_side [SinStages+1];
    logic [15:0]        cos_angle;
    logic signed [18:0] sin_q, cos_q, nsin_q;

    // local stage
    logic signed [42:0] n_ma, n_mb, n_mc, n_md;
    logic signed [24:0] r_la, r_lb, r_lc, r_ld;

    // product stage
    logic signed [56:0] n_pa_la, n_pb_lc, n_pa_lb, n_pb_ld;
    logic signed [56:0] n_pc_la, n_pd_lc, n_pc_lb, n_pd_ld;
    logic signed [63:0] r_p [12];
    logic signed [31:0] r_btx, r_bty;

    t_ent e_a, e_b, e_c, e_d, e_tx, e_ty;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    assign cos_angle = i_angle + QuarterTurn;

    atw2d_sin u_sin (.i_clk(i_clk), .i_angle(i_angle),   .o_sin(sin_q));
    atw2d_sin u_cos (.i_clk(i_clk), .i_angle(cos_angle), .o_sin(cos_q));

    // Advance the valid bits with the data; one bit per stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[5:0], accept};
        end
    end

    always_comb begin
        n_side.pos_x   = i_pos_x;
        n_side.pos_y   = i_pos_y;
        n_side.scale_x = i_scale_x;
        n_side.scale_y = i_scale_y;
        n_side.pa      = i_parent_a;
        n_side.pb      = i_parent_b;
        n_side.pc      = i_parent_c;
        n_side.pd      = i_parent_d;
        n_side.ptx     = i_parent_tx;
        n_side.pty     = i_parent_ty;
    end

    // Hold the side fields in step with the sine pipeline
    always_ff @(posedge i_clk) begin
        r_side[0] <= n_side;
        for (int i = 1; i < SinStages; i++) begin
            r_side[i] <= r_side[i-1];
        end
        r_side[SinStages] <= r_side[SinStages-1];
    end

    // Local linear part: each product rounded half up to Q9.16
    assign nsin_q = -sin_q;
    always_comb begin
        n_ma = cos_q  * r_side[SinStages-1].scale_x + 43'sd32768;
        n_mb = sin_q  * r_side[SinStages-1].scale_y + 43'sd32768;
        n_mc = nsin_q * r_side[SinStages-1].scale_x + 43'sd32768;
        n_md = cos_q  * r_side[SinStages-1].scale_y + 43'sd32768;
    end

    always_ff @(posedge i_clk) begin
        r_la <= n_ma[40:16];
        r_lb <= n_mb[40:16];
        r_lc <= n_mc[40:16];
        r_ld <= n_md[40:16];
    end

    // Parent times local: all twelve products in one stage
    always_comb begin
        n_pa_la = r_side[SinStages].pa * r_la;
        n_pb_lc = r_side[SinStages].pb * r_lc;
        n_pa_lb = r_side[SinStages].pa * r_lb;
        n_pb_ld = r_side[SinStages].pb * r_ld;
        n_pc_la = r_side[SinStages].pc * r_la;
        n_pd_lc = r_side[SinStages].pd * r_lc;
        n_pc_lb = r_side[SinStages].pc * r_lb;
        n_pd_ld = r_side[SinStages].pd * r_ld;
    end

    always_ff @(posedge i_clk) begin
        r_p[0]  <= 64'(n_pa_la);
        r_p[1]  <= 64'(n_pb_lc);
        r_p[2]  <= 64'(n_pa_lb);
        r_p[3]  <= 64'(n_pb_ld);
        r_p[4]  <= 64'(n_pc_la);
        r_p[5]  <= 64'(n_pd_lc);
        r_p[6]  <= 64'(n_pc_lb);
        r_p[7]  <= 64'(n_pd_ld);
        r_p[8]  <= r_side[SinStages].pa * r_side[SinStages].pos_x;
        r_p[9]  <= r_side[SinStages].pb * r_side[SinStages].pos_y;
        r_p[10] <= r_side[SinStages].pc * r_side[SinStages].pos_x;
        r_p[11] <= r_side[SinStages].pd * r_side[SinStages].pos_y;
        r_btx   <= r_side[SinStages].ptx;
        r_bty   <= r_side[SinStages].pty;
    end

    // Sum pairs, round once, add the parent translation, saturate
    always_comb begin
        e_a  = combine(r_p[0],  r_p[1],  32'sd0);
        e_b  = combine(r_p[2],  r_p[3],  32'sd0);
        e_c  = combine(r_p[4],  r_p[5],  32'sd0);
        e_d  = combine(r_p[6],  r_p[7],  32'sd0);
        e_tx = combine(r_p[8],  r_p[9],  r_btx);
        e_ty = combine(r_p[10], r_p[11], r_bty);
    end

    always_ff @(posedge i_clk) begin
        o_world_a  <= e_a.val;
        o_world_b  <= e_b.val;
        o_world_c  <= e_c.val;
        o_world_d  <= e_d.val;
        o_world_tx <= e_tx.val;
        o_world_ty <= e_ty.val;
        o_clipped  <= e_a.clip | e_b.clip | e_c.clip | e_d.clip | e_tx.clip | e_ty.clip;
    end

    assign o_valid = r_vld[6];

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##7 o_valid)
        else $error("accepted beat did not emerge after seven cycles");

    a_sin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> (sin_q <= 19'sd65536 && sin_q >= -19'sd65536 &&
                      cos_q <= 19'sd65536 && cos_q >= -19'sd65536))
        else $error("sine or cosine outside unit range");

    a_clip_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clipped) |->
            (o_world_a == 32'sh7FFFFFFF || o_world_a == -32'sh80000000 ||
             o_world_b == 32'sh7FFFFFFF || o_world_b == -32'sh80000000 ||
             o_world_c == 32'sh7FFFFFFF || o_world_c == -32'sh80000000 ||
             o_world_d == 32'sh7FFFFFFF || o_world_d == -32'sh80000000 ||
             o_world_tx == 32'sh7FFFFFFF || o_world_tx == -32'sh80000000 ||
             o_world_ty == 32'sh7FFFFFFF || o_world_ty == -32'sh80000000))
        else $error("clip flag set with no saturated entry");
`endif

endmodule
